/* design/hba_pkg.sv */
// Shared definitions for the histogram bin accumulator.
// Field widths, command and status codes, register indexes and defaults.
// No dependencies.
package hba_pkg;

   localparam int MAX_BINS_DEFAULT = 1024;

   localparam int CMD_W    = 2;
   localparam int DIST_W   = 32;
   localparam int WEIGHT_W = 24;
   localparam int CORR_W   = 48;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 64;
   localparam int BIU_W    = 11;
   localparam int BW_W     = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;
   localparam int PROD_W   = DIST_W + WEIGHT_W;

   localparam logic [CMD_W-1:0] CMD_INSERT_FINITE   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_INSERT_INFINITE = 2'd1;
   localparam logic [CMD_W-1:0] CMD_ADJUST          = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ            = 2'd3;

   localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
   localparam logic [STATUS_W-1:0] ST_WIDTH_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_PARTIAL    = 2'd2;
   localparam logic [STATUS_W-1:0] ST_RANGE      = 2'd3;

   localparam logic [CSR_IDX_W-1:0] REG_BINS_IN_USE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_BIN_WIDTH   = 2'd1;

   localparam logic [BIU_W-1:0] BINS_IN_USE_RESET = 11'd1024;
   localparam logic [BW_W-1:0]  BIN_WIDTH_RESET   = 32'd1;

endpackage

/* design/hba_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Used for the bin counter store. No dependencies.
module hba_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* design/histogram_bin_accumulator_unit.sv */
// Histogram bin accumulator top level: sequencer, shared multiplier and subtractor.
// Depends on hba_pkg and hba_ram.
//
// Weighted histogram of MAX_BINS 64-bit bin counters plus infinity, overflow and running-sum
// counters. One item is worked at a time; req_stall is high from acceptance until the block
// is back in idle. An insert finite finds its bin by one-bit-per-cycle restoring division by
// bin_width in the shared 64-bit subtractor, after the multiply and range compare; an insert
// that lands in overflow skips the division. A negative adjust walks bin by bin through the
// bin RAM by read-modify-write. The result sits in an output register, so the next item is
// taken while it waits. After reset a clearing pass writes zero to every bin, during which no
// item is accepted; configuration writes are taken at all times and must only be issued
// while the block is idle.
module histogram_bin_accumulator_unit #(
   parameter int MAX_BINS = hba_pkg::MAX_BINS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [hba_pkg::CMD_W-1:0]       req_command,
   input  logic [hba_pkg::DIST_W-1:0]      req_distance,
   input  logic [hba_pkg::WEIGHT_W-1:0]    req_weight,
   input  logic signed [hba_pkg::CORR_W-1:0] req_correction,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [hba_pkg::STATUS_W-1:0]    rsp_status,
   output logic [hba_pkg::COUNT_W-1:0]     rsp_bin_count,
   output logic [hba_pkg::COUNT_W-1:0]     rsp_total_sum,
   output logic [hba_pkg::COUNT_W-1:0]     rsp_infinite_count,
   output logic [hba_pkg::COUNT_W-1:0]     rsp_overflow_count,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [hba_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [hba_pkg::CSR_DATA_W-1:0]  csr_data
);

   localparam int AW  = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
   localparam int NBW = $clog2(MAX_BINS + 1);
   localparam int CW  = (NBW > hba_pkg::BIU_W) ? NBW : hba_pkg::BIU_W;
   localparam int SW  = $clog2(AW + 1);
   localparam int DSW = hba_pkg::BW_W + AW;
   localparam int CNT = hba_pkg::COUNT_W;
   localparam int PW  = hba_pkg::PROD_W;

   localparam logic [3:0] S_CLEAR   = 4'd0;
   localparam logic [3:0] S_IDLE    = 4'd1;
   localparam logic [3:0] S_MUL_P   = 4'd2;
   localparam logic [3:0] S_MUL_L   = 4'd3;
   localparam logic [3:0] S_CMP     = 4'd4;
   localparam logic [3:0] S_DIV     = 4'd5;
   localparam logic [3:0] S_RD      = 4'd6;
   localparam logic [3:0] S_WR      = 4'd7;
   localparam logic [3:0] S_RDB     = 4'd8;
   localparam logic [3:0] S_ADJ_RD  = 4'd9;
   localparam logic [3:0] S_ADJ_WR  = 4'd10;
   localparam logic [3:0] S_ADJ_END = 4'd11;
   localparam logic [3:0] S_DONE    = 4'd12;

   // control registers
   logic [3:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic [hba_pkg::BIU_W-1:0] bins_ff, bins_in;
   logic [hba_pkg::BW_W-1:0]  bw_ff, bw_in;
   logic [CNT-1:0] grand_ff, grand_in;
   logic [CNT-1:0] inf_ff, inf_in;
   logic [CNT-1:0] ovf_ff, ovf_in;

   // working registers
   logic [hba_pkg::DIST_W-1:0]   dist_ff, dist_in;
   logic [hba_pkg::WEIGHT_W-1:0] wt_ff, wt_in;
   logic [hba_pkg::CORR_W-1:0]   corr_ff, corr_in;
   logic [PW-1:0]  prod_ff, prod_in;
   logic [PW-1:0]  limit_ff, limit_in;
   logic [PW-1:0]  rem_ff, rem_in;
   logic [DSW-1:0] dsr_ff, dsr_in;
   logic [SW-1:0]  step_ff, step_in;
   logic [AW-1:0]  addr_ff, addr_in;
   logic [CNT-1:0] addend_ff, addend_in;
   logic [CNT-1:0] deficit_ff, deficit_in;
   logic [hba_pkg::STATUS_W-1:0] status_ff, status_in;
   logic [CNT-1:0] count_ff, count_in;

   // output registers
   logic [hba_pkg::STATUS_W-1:0] rsp_status_ff, rsp_status_in;
   logic [CNT-1:0] rsp_count_ff, rsp_count_in;
   logic [CNT-1:0] rsp_sum_ff, rsp_sum_in;
   logic [CNT-1:0] rsp_inf_ff, rsp_inf_in;
   logic [CNT-1:0] rsp_ovf_ff, rsp_ovf_in;

   logic req_accept;
   logic [CW-1:0]  biu_ext;
   logic [NBW-1:0] nb;
   logic [AW:0]    addr_next;

   // shared multiplier and subtractor
   logic [hba_pkg::DIST_W-1:0]   mul_a;
   logic [hba_pkg::WEIGHT_W-1:0] mul_b;
   logic [PW-1:0]  mul_p;
   logic [CNT-1:0] sub_a, sub_b;
   logic [CNT:0]   sub_diff;
   logic           sub_borrow;
   logic [CNT-1:0] sub_neg;

   logic           ram_wr_en;
   logic [CNT-1:0] ram_wr_data;
   logic [AW-1:0]  ram_rd_addr;
   logic [CNT-1:0] ram_rd_data;
   logic [AW:0]    q_shift;

   hba_ram #(
      .WIDTH (CNT),
      .DEPTH (MAX_BINS)
   ) u_bins (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (addr_ff),
      .wr_data (ram_wr_data),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign csr_ready  = 1'b1;

   // clamp bins_in_use to the store depth
   assign biu_ext = CW'(bins_ff);
   assign nb = (biu_ext > CW'(MAX_BINS)) ? NBW'(MAX_BINS) : NBW'(biu_ext);
   assign addr_next = {1'b0, addr_ff} + (AW+1)'(1);

   always_comb begin
      mul_a = (state_ff == S_MUL_L) ? bw_ff : dist_ff;
      mul_b = (state_ff == S_MUL_L) ? hba_pkg::WEIGHT_W'(nb) : wt_ff;
   end
   assign mul_p = PW'(mul_a) * PW'(mul_b);

   always_comb begin
      unique case (state_ff)
         S_CMP: begin
            sub_a = CNT'(prod_ff);
            sub_b = CNT'(limit_ff);
         end
         S_DIV: begin
            sub_a = CNT'(rem_ff);
            sub_b = CNT'(dsr_ff);
         end
         default: begin
            sub_a = ram_rd_data;
            sub_b = deficit_ff;
         end
      endcase
   end
   assign sub_diff   = {1'b0, sub_a} - {1'b0, sub_b};
   assign sub_borrow = sub_diff[CNT];
   assign sub_neg    = CNT'(0) - sub_diff[CNT-1:0];
   assign q_shift    = {addr_ff, ~sub_borrow};

   assign ram_rd_addr = (state_ff == S_IDLE) ? req_distance[AW-1:0] : addr_ff;

   always_comb begin
      ram_wr_en   = 1'b0;
      ram_wr_data = '0;
      unique case (state_ff)
         S_CLEAR: ram_wr_en = 1'b1;
         S_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = ram_rd_data + addend_ff;
         end
         S_ADJ_WR: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = sub_borrow ? '0 : sub_diff[CNT-1:0];
         end
         default: ram_wr_en = 1'b0;
      endcase
   end

   // configuration writes
   always_comb begin
      bins_in = bins_ff;
      bw_in   = bw_ff;
      if (csr_valid && csr_ready) begin
         if (csr_index == hba_pkg::REG_BINS_IN_USE) begin
            bins_in = csr_data[hba_pkg::BIU_W-1:0];
         end else if (csr_index == hba_pkg::REG_BIN_WIDTH) begin
            bw_in = csr_data[hba_pkg::BW_W-1:0];
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      grand_in     = grand_ff;
      inf_in       = inf_ff;
      ovf_in       = ovf_ff;
      dist_in      = dist_ff;
      wt_in        = wt_ff;
      corr_in      = corr_ff;
      prod_in      = prod_ff;
      limit_in     = limit_ff;
      rem_in       = rem_ff;
      dsr_in       = dsr_ff;
      step_in      = step_ff;
      addr_in      = addr_ff;
      addend_in    = addend_ff;
      deficit_in   = deficit_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;
      rsp_sum_in    = rsp_sum_ff;
      rsp_inf_in    = rsp_inf_ff;
      rsp_ovf_in    = rsp_ovf_ff;

      unique case (state_ff)
         S_CLEAR: begin
            addr_in = addr_next[AW-1:0];
            if (addr_ff == AW'(MAX_BINS - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               dist_in   = req_distance;
               wt_in     = req_weight;
               corr_in   = req_correction;
               status_in = hba_pkg::ST_OK;
               count_in  = '0;
               addr_in   = '0;
               unique case (req_command)
                  hba_pkg::CMD_INSERT_FINITE: begin
                     if (bw_ff == '0) begin
                        status_in = hba_pkg::ST_WIDTH_ZERO;
                        state_in  = S_DONE;
                     end else begin
                        state_in = S_MUL_P;
                     end
                  end
                  hba_pkg::CMD_INSERT_INFINITE: begin
                     inf_in   = inf_ff + CNT'(req_weight);
                     grand_in = grand_ff + CNT'(req_weight);
                     state_in = S_DONE;
                  end
                  hba_pkg::CMD_ADJUST: begin
                     if (bw_ff == '0) begin
                        status_in = hba_pkg::ST_WIDTH_ZERO;
                        state_in  = S_DONE;
                     end else if (nb == '0) begin
                        status_in = hba_pkg::ST_PARTIAL;
                        state_in  = S_DONE;
                     end else if (!req_correction[hba_pkg::CORR_W-1]) begin
                        addend_in = CNT'(unsigned'(req_correction));
                        state_in  = S_RD;
                     end else begin
                        deficit_in = CNT'(0) - CNT'(req_correction);
                        state_in   = S_ADJ_RD;
                     end
                  end
                  hba_pkg::CMD_READ: begin
                     if (req_distance < hba_pkg::DIST_W'(nb)) begin
                        state_in = S_RDB;
                     end else begin
                        status_in = hba_pkg::ST_RANGE;
                        state_in  = S_DONE;
                     end
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_MUL_P: begin
            prod_in  = mul_p;
            state_in = S_MUL_L;
         end
         S_MUL_L: begin
            limit_in = mul_p;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (sub_borrow) begin
               // product inside the bins: find the bin by division
               rem_in    = prod_ff;
               dsr_in    = DSW'(bw_ff) << (AW - 1);
               step_in   = SW'(AW - 1);
               addend_in = CNT'(wt_ff);
               state_in  = S_DIV;
            end else begin
               ovf_in   = ovf_ff + CNT'(wt_ff);
               grand_in = grand_ff + CNT'(wt_ff);
               state_in = S_DONE;
            end
         end
         S_DIV: begin
            if (!sub_borrow) begin
               rem_in = sub_diff[PW-1:0];
            end
            addr_in = q_shift[AW-1:0];
            dsr_in  = dsr_ff >> 1;
            if (step_ff == '0) begin
               state_in = S_RD;
            end else begin
               step_in = step_ff - SW'(1);
            end
         end
         S_RD: state_in = S_WR;
         S_WR: begin
            grand_in = grand_ff + addend_ff;
            state_in = S_DONE;
         end
         S_RDB: begin
            count_in = ram_rd_data;
            state_in = S_DONE;
         end
         S_ADJ_RD: state_in = S_ADJ_WR;
         S_ADJ_WR: begin
            if (!sub_borrow) begin
               deficit_in = '0;
               state_in   = S_ADJ_END;
            end else begin
               // bin drained: carry the rest of the deficit on
               deficit_in = sub_neg;
               addr_in    = addr_next[AW-1:0];
               if (addr_next == (AW+1)'(nb)) begin
                  state_in = S_ADJ_END;
               end else begin
                  state_in = S_ADJ_RD;
               end
            end
         end
         S_ADJ_END: begin
            grand_in  = grand_ff + CNT'(signed'(corr_ff)) + deficit_ff;
            status_in = (deficit_ff != '0) ? hba_pkg::ST_PARTIAL : hba_pkg::ST_OK;
            state_in  = S_DONE;
         end
         S_DONE: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_count_in  = count_ff;
               rsp_sum_in    = grand_ff;
               rsp_inf_in    = inf_ff;
               rsp_ovf_in    = ovf_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
         bins_ff      <= hba_pkg::BINS_IN_USE_RESET;
         bw_ff        <= hba_pkg::BIN_WIDTH_RESET;
         grand_ff     <= '0;
         inf_ff       <= '0;
         ovf_ff       <= '0;
         addr_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         bins_ff      <= bins_in;
         bw_ff        <= bw_in;
         grand_ff     <= grand_in;
         inf_ff       <= inf_in;
         ovf_ff       <= ovf_in;
         addr_ff      <= addr_in;
      end
   end

   always_ff @(posedge clock) begin
      dist_ff       <= dist_in;
      wt_ff         <= wt_in;
      corr_ff       <= corr_in;
      prod_ff       <= prod_in;
      limit_ff      <= limit_in;
      rem_ff        <= rem_in;
      dsr_ff        <= dsr_in;
      step_ff       <= step_in;
      addend_ff     <= addend_in;
      deficit_ff    <= deficit_in;
      status_ff     <= status_in;
      count_ff      <= count_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_sum_ff    <= rsp_sum_in;
      rsp_inf_ff    <= rsp_inf_in;
      rsp_ovf_ff    <= rsp_ovf_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_bin_count      = rsp_count_ff;
   assign rsp_total_sum      = rsp_sum_ff;
   assign rsp_infinite_count = rsp_inf_ff;
   assign rsp_overflow_count = rsp_ovf_ff;

endmodule
